// ===== design/stl_pkg.sv =====
// shared types, constants and helper functions of the script token lexer
`timescale 1ns / 1ps

package stl_pkg;

    // field widths
    localparam int LENGTH_BITS = 16;
    localparam int POS_BITS    = 32;
    localparam int LINE_BITS   = 24;
    localparam int KIND_BITS   = 6;

    // results one request can cause and the count width for them
    localparam int MAX_RES = 3;
    localparam int BC_W    = $clog2(MAX_RES + 1);

    // result queue geometry (depth is a power of two so pointers wrap)
    localparam int RQ_DEPTH = 4;
    localparam int RQ_AW    = $clog2(RQ_DEPTH);
    localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);

    // identifier prefix kept for the keyword compare
    localparam int PREFIX_BYTES = 5;
    localparam int PREFIX_BITS  = 8 * PREFIX_BYTES;

    localparam logic [LINE_BITS-1:0] LINE_MAX   = '1;
    localparam logic [LINE_BITS-1:0] LINE_FIRST = LINE_BITS'(1);

    // token kinds
    typedef logic [KIND_BITS-1:0] t_kind;
    localparam t_kind K_NEWLINE    = 6'd0;
    localparam t_kind K_STRING     = 6'd1;
    localparam t_kind K_NUMBER     = 6'd2;
    localparam t_kind K_IDENT      = 6'd3;
    localparam t_kind K_KW_BASE    = 6'd4;
    localparam t_kind K_COLON_EQ   = 6'd13;
    localparam t_kind K_EQ_EQ      = 6'd14;
    localparam t_kind K_NOT_EQ     = 6'd15;
    localparam t_kind K_LESS_EQ    = 6'd16;
    localparam t_kind K_GREATER_EQ = 6'd17;
    localparam t_kind K_OP_BASE    = 6'd18;
    localparam t_kind K_END        = 6'd34;

    // source characters with a role of their own
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [7:0] CH_DQUOTE     = 8'h22;
    localparam logic [7:0] CH_SQUOTE     = 8'h27;
    localparam logic [7:0] CH_BANG       = 8'h21;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_COLON      = 8'h3A;
    localparam logic [7:0] CH_LESS       = 8'h3C;
    localparam logic [7:0] CH_EQUAL      = 8'h3D;
    localparam logic [7:0] CH_GREATER    = 8'h3E;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_DIGIT_LO   = 8'h30;
    localparam logic [7:0] CH_DIGIT_HI   = 8'h39;
    localparam logic [7:0] CH_UPPER_LO   = 8'h41;
    localparam logic [7:0] CH_UPPER_HI   = 8'h5A;
    localparam logic [7:0] CH_LOWER_LO   = 8'h61;
    localparam logic [7:0] CH_LOWER_HI   = 8'h7A;

    // single-character operators, in kind order from K_OP_BASE
    localparam int N_SINGLE = 16;
    localparam logic [7:0] SINGLE_OPS [N_SINGLE] = '{
        8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h25, 8'h3C, 8'h3E, 8'h3D,
        8'h28, 8'h29, 8'h5B, 8'h5D, 8'h2C, 8'h2E, 8'h3A, 8'h3F
    };

    // keywords packed right-aligned, in kind order from K_KW_BASE
    localparam int N_KEYWORDS = 9;
    localparam logic [PREFIX_BITS-1:0] KW_PACK [N_KEYWORDS] = '{
        40'h00_0061_6E64,   // and
        40'h00_0000_6F72,   // or
        40'h00_006E_6F74,   // not
        40'h00_7472_7565,   // true
        40'h66_616C_7365,   // false
        40'h00_0000_6E61,   // na
        40'h00_0076_6172,   // var
        40'h00_0000_6966,   // if
        40'h00_656C_7365    // else
    };

    // lexer modes
    typedef enum logic [2:0] {
        M_IDLE,
        M_PEND,
        M_COMMENT,
        M_STRING,
        M_NUMBER,
        M_IDENT
    } t_mode;

    // input request
    typedef struct packed {
        logic [7:0] ch;
        logic       char_valid;
        logic       end_of_source;
    } t_in;

    // one token record
    typedef struct packed {
        t_kind                  token_kind;
        logic [POS_BITS-1:0]    token_start;
        logic [LENGTH_BITS-1:0] token_length;
        logic [LINE_BITS-1:0]   token_line;
        logic                   last_of_run;
    } t_res;

    // all records caused by one input request
    typedef struct packed {
        logic [BC_W-1:0]          count;
        t_res [MAX_RES-1:0]       item;
    } t_batch;

    // operator lookup result
    typedef struct packed {
        logic  hit;
        t_kind kind;
    } t_tok;

    // result queue status toward the top level
    typedef struct packed {
        logic space_ok;
        logic valid;
    } t_rq_stat;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_DIGIT_LO) && (c <= CH_DIGIT_HI);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= CH_LOWER_LO) && (c <= CH_LOWER_HI)) ||
               ((c >= CH_UPPER_LO) && (c <= CH_UPPER_HI));
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == CH_UNDERSCORE);
    endfunction

    function automatic t_tok single_op(input logic [7:0] c);
        t_tok t;
        t = '0;
        for (int k = 0; k < N_SINGLE; k++) begin
            if (c == SINGLE_OPS[k]) begin
                t.hit  = 1'b1;
                t.kind = K_OP_BASE + KIND_BITS'(k);
            end
        end
        return t;
    endfunction

    function automatic t_tok two_op(input logic [7:0] first);
        t_tok t;
        t = '0;
        t.hit = 1'b1;
        case (first)
            CH_COLON:   t.kind = K_COLON_EQ;
            CH_EQUAL:   t.kind = K_EQ_EQ;
            CH_BANG:    t.kind = K_NOT_EQ;
            CH_LESS:    t.kind = K_LESS_EQ;
            CH_GREATER: t.kind = K_GREATER_EQ;
            default:    t.hit  = 1'b0;
        endcase
        return t;
    endfunction

    function automatic t_kind word_kind(input logic [PREFIX_BITS-1:0] prefix,
                                        input logic [LENGTH_BITS-1:0] len,
                                        input logic                   overlong);
        t_kind kind;
        kind = K_IDENT;
        if (!overlong && (len <= LENGTH_BITS'(PREFIX_BYTES))) begin
            for (int k = 0; k < N_KEYWORDS; k++) begin
                if (KW_PACK[k] == prefix) begin
                    kind = K_KW_BASE + KIND_BITS'(k);
                end
            end
        end
        return kind;
    endfunction

    function automatic logic [LENGTH_BITS-1:0] grow(input logic [LENGTH_BITS-1:0] len);
        return (len == '1) ? len : len + LENGTH_BITS'(1);
    endfunction

endpackage

// ===== design/stl_lex.sv =====
// lexer state and the single-pass token decision for one source byte
`timescale 1ns / 1ps

module stl_lex
    import stl_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_take,
    input  t_in    i_req,
    output t_batch o_batch
);

    localparam int N_CAND = 4;

    // lexer state
    t_mode                  r_mode;
    logic [7:0]             r_pend;
    logic [7:0]             r_quote;
    logic [POS_BITS-1:0]    r_start;
    logic [LENGTH_BITS-1:0] r_len;
    logic [POS_BITS-1:0]    r_pos;
    logic [LINE_BITS-1:0]   r_line;
    logic [PREFIX_BITS-1:0] r_prefix;
    logic                   r_over;

    t_mode                  n_mode;
    logic [7:0]             n_pend;
    logic [7:0]             n_quote;
    logic [POS_BITS-1:0]    n_start;
    logic [LENGTH_BITS-1:0] n_len;
    logic [POS_BITS-1:0]    n_pos;
    logic [LINE_BITS-1:0]   n_line;
    logic [PREFIX_BITS-1:0] n_prefix;
    logic                   n_over;

    // state after the byte, before any end-of-source flush
    t_mode                  m_mode;
    logic [7:0]             m_pend;
    logic [7:0]             m_quote;
    logic [POS_BITS-1:0]    m_start;
    logic [LENGTH_BITS-1:0] m_len;
    logic [POS_BITS-1:0]    m_pos;
    logic [LINE_BITS-1:0]   m_line;
    logic [PREFIX_BITS-1:0] m_prefix;
    logic                   m_over;

    logic [7:0] c;
    t_tok       c_op;
    t_tok       pend_op;
    t_tok       pend_two;
    t_tok       flush_op;

    // classification of a byte that starts fresh
    t_mode f_mode;
    logic  f_hit;
    t_kind f_kind;
    logic  f_inc;

    logic do_fresh;

    // candidate records: byte result, fresh-start result, flush, end
    t_res cand   [N_CAND];
    logic cand_v [N_CAND];

    logic [BC_W-1:0] cnt;

    assign c        = i_req.ch;
    assign c_op     = single_op(c);
    assign pend_op  = single_op(r_pend);
    assign pend_two = two_op(r_pend);
    assign flush_op = single_op(m_pend);

    // what a byte does when no token is open
    always_comb begin
        f_mode = M_IDLE;
        f_hit  = 1'b0;
        f_kind = K_NEWLINE;
        f_inc  = 1'b0;
        priority if (c == CH_NEWLINE) begin
            f_hit = 1'b1;
            f_inc = 1'b1;
        end else if ((c == CH_DQUOTE) || (c == CH_SQUOTE)) begin
            f_mode = M_STRING;
        end else if (is_digit(c)) begin
            f_mode = M_NUMBER;
        end else if (is_alpha(c) || (c == CH_UNDERSCORE)) begin
            f_mode = M_IDENT;
        end else if ((c == CH_SLASH) || (c == CH_DOT) || (c == CH_COLON) ||
                     (c == CH_EQUAL) || (c == CH_BANG) || (c == CH_LESS) ||
                     (c == CH_GREATER)) begin
            f_mode = M_PEND;
        end else begin
            f_hit  = c_op.hit;
            f_kind = c_op.kind;
        end
    end

    // byte step: mode transitions and the records they close
    always_comb begin
        m_mode   = r_mode;
        m_pend   = r_pend;
        m_quote  = r_quote;
        m_start  = r_start;
        m_len    = r_len;
        m_line   = r_line;
        m_prefix = r_prefix;
        m_over   = r_over;
        m_pos    = r_pos;
        do_fresh = 1'b0;

        cand_v[0]              = 1'b0;
        cand[0].token_kind     = K_NEWLINE;
        cand[0].token_start    = r_start;
        cand[0].token_length   = LENGTH_BITS'(1);
        cand[0].token_line     = r_line;
        cand[0].last_of_run    = 1'b0;

        if (i_req.char_valid) begin
            m_pos = r_pos + POS_BITS'(1);
            unique case (r_mode)
                M_PEND: begin
                    if ((r_pend == CH_SLASH) && (c == CH_SLASH)) begin
                        m_mode = M_COMMENT;
                    end else if ((r_pend == CH_DOT) && is_digit(c)) begin
                        m_mode = M_NUMBER;
                        m_len  = LENGTH_BITS'(2);
                    end else if ((c == CH_EQUAL) && pend_two.hit) begin
                        cand_v[0]            = 1'b1;
                        cand[0].token_kind   = pend_two.kind;
                        cand[0].token_length = LENGTH_BITS'(2);
                        m_mode               = M_IDLE;
                    end else begin
                        cand_v[0]          = pend_op.hit;
                        cand[0].token_kind = pend_op.kind;
                        do_fresh           = 1'b1;
                    end
                end
                M_COMMENT: begin
                    do_fresh = (c == CH_NEWLINE);
                end
                M_STRING: begin
                    if (c == r_quote) begin
                        cand_v[0]            = 1'b1;
                        cand[0].token_kind   = K_STRING;
                        cand[0].token_length = r_len;
                        m_mode               = M_IDLE;
                    end else begin
                        m_len = grow(r_len);
                    end
                end
                M_NUMBER: begin
                    if (is_digit(c) || (c == CH_DOT)) begin
                        m_len = grow(r_len);
                    end else begin
                        cand_v[0]            = 1'b1;
                        cand[0].token_kind   = K_NUMBER;
                        cand[0].token_length = r_len;
                        do_fresh             = 1'b1;
                    end
                end
                M_IDENT: begin
                    if (is_word(c)) begin
                        if (r_len < LENGTH_BITS'(PREFIX_BYTES)) begin
                            m_prefix = {r_prefix[PREFIX_BITS-9:0], c};
                        end else begin
                            m_over = 1'b1;
                        end
                        m_len = grow(r_len);
                    end else begin
                        cand_v[0]            = 1'b1;
                        cand[0].token_kind   = word_kind(r_prefix, r_len, r_over);
                        cand[0].token_length = r_len;
                        do_fresh             = 1'b1;
                    end
                end
                default: begin
                    do_fresh = 1'b1;
                end
            endcase

            // start over with the current byte
            if (do_fresh) begin
                m_mode = f_mode;
                unique case (f_mode)
                    M_STRING: begin
                        m_quote = c;
                        m_start = r_pos + POS_BITS'(1);
                        m_len   = '0;
                    end
                    M_NUMBER: begin
                        m_start = r_pos;
                        m_len   = LENGTH_BITS'(1);
                    end
                    M_IDENT: begin
                        m_start  = r_pos;
                        m_len    = LENGTH_BITS'(1);
                        m_prefix = PREFIX_BITS'(c);
                        m_over   = 1'b0;
                    end
                    M_PEND: begin
                        m_pend  = c;
                        m_start = r_pos;
                    end
                    default: begin
                    end
                endcase
                if (f_inc && (r_line != LINE_MAX)) begin
                    m_line = r_line + LINE_BITS'(1);
                end
            end
        end

        // record from the fresh start
        cand_v[1]            = do_fresh && f_hit;
        cand[1].token_kind   = f_kind;
        cand[1].token_start  = r_pos;
        cand[1].token_length = LENGTH_BITS'(1);
        cand[1].token_line   = r_line;
        cand[1].last_of_run  = 1'b0;

        // flush of the open token at end of source
        cand_v[2]            = 1'b0;
        cand[2].token_kind   = K_STRING;
        cand[2].token_start  = m_start;
        cand[2].token_length = m_len;
        cand[2].token_line   = m_line;
        cand[2].last_of_run  = 1'b0;
        unique case (m_mode)
            M_PEND: begin
                cand_v[2]            = flush_op.hit;
                cand[2].token_kind   = flush_op.kind;
                cand[2].token_length = LENGTH_BITS'(1);
            end
            M_STRING: begin
                cand_v[2] = 1'b1;
            end
            M_NUMBER: begin
                cand_v[2]          = 1'b1;
                cand[2].token_kind = K_NUMBER;
            end
            M_IDENT: begin
                cand_v[2]          = 1'b1;
                cand[2].token_kind = word_kind(m_prefix, m_len, m_over);
            end
            default: begin
            end
        endcase
        cand_v[2] = cand_v[2] && i_req.end_of_source;

        // end token
        cand_v[3]            = i_req.end_of_source;
        cand[3].token_kind   = K_END;
        cand[3].token_start  = m_pos;
        cand[3].token_length = '0;
        cand[3].token_line   = m_line;
        cand[3].last_of_run  = 1'b0;
    end

    // pack the records in order and mark the last one
    always_comb begin
        cnt     = '0;
        o_batch = '0;
        for (int i = 0; i < N_CAND; i++) begin
            if (cand_v[i] && (cnt < BC_W'(MAX_RES))) begin
                o_batch.item[cnt] = cand[i];
                cnt               = cnt + BC_W'(1);
            end
        end
        for (int j = 0; j < MAX_RES; j++) begin
            o_batch.item[j].last_of_run = (cnt == BC_W'(j + 1));
        end
        o_batch.count = cnt;
    end

    // next state: back to reset values after the end token
    always_comb begin
        if (i_req.end_of_source) begin
            n_mode   = M_IDLE;
            n_pend   = '0;
            n_quote  = '0;
            n_start  = '0;
            n_len    = '0;
            n_pos    = '0;
            n_line   = LINE_FIRST;
            n_prefix = '0;
            n_over   = 1'b0;
        end else begin
            n_mode   = m_mode;
            n_pend   = m_pend;
            n_quote  = m_quote;
            n_start  = m_start;
            n_len    = m_len;
            n_pos    = m_pos;
            n_line   = m_line;
            n_prefix = m_prefix;
            n_over   = m_over;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_IDLE;
            r_pend   <= '0;
            r_quote  <= '0;
            r_start  <= '0;
            r_len    <= '0;
            r_pos    <= '0;
            r_line   <= LINE_FIRST;
            r_prefix <= '0;
            r_over   <= 1'b0;
        end else if (i_take) begin
            r_mode   <= n_mode;
            r_pend   <= n_pend;
            r_quote  <= n_quote;
            r_start  <= n_start;
            r_len    <= n_len;
            r_pos    <= n_pos;
            r_line   <= n_line;
            r_prefix <= n_prefix;
            r_over   <= n_over;
        end
    end

endmodule

// ===== design/stl_resq.sv =====
// small result queue that takes up to three records at once and drains one per cycle while the reader is ready
`timescale 1ns / 1ps

module stl_resq
    import stl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_batch   i_batch,
    input  logic     i_ready,
    output t_rq_stat o_stat,
    output t_res     o_res
);

    t_res             r_mem [RQ_DEPTH];
    logic [RQ_AW-1:0] r_wr;
    logic [RQ_AW-1:0] r_rd;
    logic [RQ_CW-1:0] r_cnt;

    logic [RQ_CW-1:0] n_cnt;
    logic [RQ_AW-1:0] n_wr;
    logic [RQ_AW-1:0] n_rd;
    logic             pop;
    logic [RQ_CW-1:0] push_n;

    // status and head record
    assign o_stat.valid    = (r_cnt != '0);
    assign o_stat.space_ok = (r_cnt <= RQ_CW'(RQ_DEPTH - MAX_RES));
    assign o_res           = r_mem[r_rd];

    // pointer and fill bookkeeping
    assign pop    = o_stat.valid && i_ready;
    assign push_n = i_push ? RQ_CW'(i_batch.count) : '0;
    assign n_cnt  = r_cnt + push_n - RQ_CW'(pop);
    assign n_wr   = r_wr + RQ_AW'(push_n);
    assign n_rd   = r_rd + RQ_AW'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wr  <= '0;
            r_rd  <= '0;
        end else begin
            r_cnt <= n_cnt;
            r_wr  <= n_wr;
            r_rd  <= n_rd;
        end
    end

    // record storage
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < MAX_RES; j++) begin
            if (i_push && (BC_W'(j) < i_batch.count)) begin
                r_mem[r_wr + RQ_AW'(j)] <= i_batch.item[j];
            end
        end
    end

endmodule

// ===== design/script_token_lexer.sv =====
// top level of the streaming script token lexer
// records of an accepted request are queued in registers and leave in order
// throughput: one source byte per cycle while records drain; each record takes one
//   output cycle, so a request causing two or three records stalls input until the
//   four-entry result queue is back to one record or fewer
// reset: synchronous, active low; clears lexer state (line 1, offset 0) and the queue
`timescale 1ns / 1ps

module script_token_lexer
    import stl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_req,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_res o_out_req
);

    t_batch   batch;
    t_rq_stat stat;
    logic     take;

    // input request accepted
    assign take       = i_in_valid && o_in_ready;
    assign o_in_ready = stat.space_ok;
    assign o_out_valid = stat.valid;

    // lexer decision and state
    stl_lex u_lex (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_req   (i_in_req),
        .o_batch (batch)
    );

    // result queue
    stl_resq u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (take),
        .i_batch (batch),
        .i_ready (i_out_ready),
        .o_stat  (stat),
        .o_res   (o_out_req)
    );

`ifndef SYNTHESIS
    // an end of source always produces at least the end token
    a_end_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_in_req.end_of_source) |-> (batch.count != '0))
        else $error("end of source without records");

    // an empty request produces nothing
    a_empty_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && !i_in_req.char_valid && !i_in_req.end_of_source) |-> (batch.count == '0))
        else $error("empty request produced records");

    // output valid only drops after a record is taken
    a_out_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(o_out_valid) && $past(i_rst_n)) |-> $past(i_out_ready))
        else $error("output valid dropped without a take");

    // an accepted request that causes records leaves records pending on the next cycle
    a_push_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && (batch.count != '0)) |=> o_out_valid)
        else $error("records lost after accept");
`endif

endmodule
